FILE: src/tcw_pkg.sv
// Package for the text console writer: field widths, codes, command and state types.
// Used by the top level and by the front and back parts; it depends on nothing else.
package tcw_pkg;

  localparam int CharW  = 8;
  localparam int CellW  = 16;
  localparam int RowFieldW = 5;
  localparam int ColFieldW = 7;

  localparam logic [CharW-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CharW-1:0] BLANK_CODE   = 8'h20;
  localparam logic [CharW-1:0] RESET_COLOR  = 8'h07;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_READ,
    OP_READ_NONE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] char_code;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN,
    ST_BLANK
  } state_e;

  function automatic logic [CellW-1:0] make_cell(input logic [CharW-1:0] ch,
                                                 input logic [CharW-1:0] attr);
    return {attr, ch};
  endfunction

endpackage

FILE: src/tcw_req_if.sv
// Request channel of the text console writer: valid/ready handshake and request payload.
// Depends on nothing.
interface tcw_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;
  logic [4:0] cell_row;
  logic [6:0] cell_col;

  modport source (output valid, req_type, char_code, cell_row, cell_col, input ready);
  modport sink   (input valid, req_type, char_code, cell_row, cell_col, output ready);
endinterface

FILE: src/tcw_rsp_if.sv
// Response channel of the text console writer: valid/ready handshake and result payload.
// Depends on nothing.
interface tcw_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_entry;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic        scrolled;

  modport source (output valid, cell_entry, cursor_row, cursor_col, scrolled, input ready);
  modport sink   (input valid, cell_entry, cursor_row, cursor_col, scrolled, output ready);
endinterface

FILE: src/text_console_writer.sv
// Top level of the text console writer: color register, front, command queue and back.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if, tcw_front, tcw_queue and tcw_back.
//
// The block keeps a ROWS x COLS screen of 16-bit cells and a cursor. Each request beat on
// req_i either puts a character at the cursor (newline moves the cursor only) or reads one
// cell; each request gives exactly one response beat on rsp_o with the cell read, the cursor
// after the request and a flag that tells whether the screen scrolled. The text color is
// written through cfg_we_i and cfg_wdata_i and applies to later characters and blanks.
// A put, a newline or an out-of-range read answers through the queue and the response
// register, a read of a cell also through the cell store's read register. A put or
// newline that leaves the bottom row scrolls: the single-port-write cell memory moves
// one cell per cycle, and the bottom row is blanked before the request answers.
// After reset a clearing pass writes blanks in color 7 to all ROWS*COLS cells, one per
// cycle, and req_i.ready stays low until it ends; the cursor starts at row 0, column 0.
// A two-entry queue lies between the front and the back, and the response sits in a
// register, so requests are still taken while a response waits on a low rsp_o.ready.
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  tcw_req_if.sink    req_i,
  tcw_rsp_if.source  rsp_o
);

  localparam int AddrW = $clog2(ROWS * COLS);
  localparam int CmdW  = $bits(tcw_pkg::cmd_t);
  localparam int QW    = AddrW + CmdW;

  logic [7:0]       text_color_q;
  logic             clearing, q_full, q_empty, push, pop;
  tcw_pkg::cmd_t    front_cmd, back_cmd;
  logic [AddrW-1:0] front_addr, back_addr;
  logic [QW-1:0]    q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcw_pkg::RESET_COLOR;
    end else if (cfg_we_i) begin
      text_color_q <= cfg_wdata_i;
    end
  end

  tcw_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
    .req_i      (req_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (front_cmd),
    .addr_o     (front_addr)
  );

  assign q_wdata = {front_addr, front_cmd};

  tcw_queue #(.DataW(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign back_cmd  = tcw_pkg::cmd_t'(q_rdata[CmdW-1:0]);
  assign back_addr = q_rdata[QW-1:CmdW];

  tcw_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_color_i (text_color_q),
    .q_empty_i    (q_empty),
    .cmd_i        (back_cmd),
    .addr_i       (back_addr),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .rsp_o        (rsp_o)
  );

endmodule

FILE: src/tcw_queue.sv
// Two-entry command queue between the front and back parts of the console writer.
// Depends on nothing; the top level sets DataW to the cell address plus packed command width.
module tcw_queue #(
  parameter int DataW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             pop_i,
  output logic [DataW-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [DataW-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;

endmodule

FILE: src/tcw_front.sv
// Front part of the console writer: takes request beats, classifies them and
// computes the cell address of reads. Depends on tcw_pkg and tcw_req_if.
module tcw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  localparam int AddrW = $clog2(ROWS * COLS)
) (
  tcw_req_if.sink          req_i,
  input  logic             clearing_i,
  input  logic             q_full_i,
  output logic             push_o,
  output tcw_pkg::cmd_t    cmd_o,
  output logic [AddrW-1:0] addr_o
);

  logic in_range;

  assign req_i.ready = !q_full_i && !clearing_i;
  assign push_o      = req_i.valid && req_i.ready;

  assign in_range = (32'(req_i.cell_row) < 32'(ROWS)) && (32'(req_i.cell_col) < 32'(COLS));

  always_comb begin
    cmd_o.char_code = req_i.char_code;
    if (req_i.req_type) begin
      cmd_o.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_READ_NONE;
    end else if (req_i.char_code == tcw_pkg::NEWLINE_CODE) begin
      cmd_o.op = tcw_pkg::OP_NEWLINE;
    end else begin
      cmd_o.op = tcw_pkg::OP_PUT;
    end
  end

  assign addr_o = AddrW'(req_i.cell_row) * AddrW'(COLS) + AddrW'(req_i.cell_col);

endmodule

FILE: src/tcw_back.sv
// Back part of the console writer: cell store, cursor, scroll and clear sequencer
// and the result register. Depends on tcw_pkg and tcw_rsp_if.
module tcw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  localparam int AddrW = $clog2(ROWS * COLS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       text_color_i,
  input  logic             q_empty_i,
  input  tcw_pkg::cmd_t    cmd_i,
  input  logic [AddrW-1:0] addr_i,
  output logic             pop_o,
  output logic             clearing_o,
  tcw_rsp_if.source        rsp_o
);

  localparam int Cells   = ROWS * COLS;
  localparam int RowW    = $clog2(ROWS);
  localparam int ColW    = $clog2(COLS);
  localparam int RowExtW = (RowW > tcw_pkg::RowFieldW) ? RowW : tcw_pkg::RowFieldW;
  localparam int ColExtW = (ColW > tcw_pkg::ColFieldW) ? ColW : tcw_pkg::ColFieldW;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Cells - 1);
  localparam logic [AddrW-1:0] ColsAddr = AddrW'(COLS);
  localparam logic [AddrW-1:0] BotBase  = AddrW'((ROWS - 1) * COLS);
  localparam logic [RowW-1:0]  LastRow  = RowW'(ROWS - 1);
  localparam logic [ColW:0]    ColsCnt  = (ColW + 1)'(COLS);

  logic [tcw_pkg::CellW-1:0] mem [Cells];
  logic [tcw_pkg::CellW-1:0] rd_data_q;
  logic                      mem_we;
  logic [AddrW-1:0]          mem_waddr, mem_raddr;
  logic [tcw_pkg::CellW-1:0] mem_wdata;

  tcw_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [AddrW-1:0] mv_addr_q, mv_addr_d;
  logic             mv_pend_q, mv_pend_d;
  logic [RowW-1:0]  cur_row_q, cur_row_d;
  logic [ColW-1:0]  cur_col_q, cur_col_d;
  logic [AddrW-1:0] row_base_q, row_base_d;
  logic [AddrW-1:0] cur_addr_q, cur_addr_d;
  logic             out_valid_q, out_valid_d;
  logic [tcw_pkg::CellW-1:0] out_entry_q, out_entry_d;
  logic [tcw_pkg::RowFieldW-1:0] out_row_q, out_row_d;
  logic [tcw_pkg::ColFieldW-1:0] out_col_q, out_col_d;
  logic             out_scr_q, out_scr_d;

  logic             out_free, load, newline, res_scr;
  logic [tcw_pkg::CellW-1:0] res_entry;
  logic [ColW:0]    col_inc;
  logic [RowExtW-1:0] row_ext;
  logic [ColExtW-1:0] col_ext;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_CLEAR;
      ptr_q       <= '0;
      mv_pend_q   <= 1'b0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      row_base_q  <= '0;
      cur_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      mv_pend_q   <= mv_pend_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      row_base_q  <= row_base_d;
      cur_addr_q  <= cur_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_addr_q   <= mv_addr_d;
    out_entry_q <= out_entry_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_scr_q   <= out_scr_d;
  end

  assign out_free = !out_valid_q || rsp_o.ready;
  assign col_inc  = {1'b0, cur_col_q} + (ColW + 1)'(1);

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    mv_addr_d  = mv_addr_q;
    mv_pend_d  = mv_pend_q;
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    row_base_d = row_base_q;
    cur_addr_d = cur_addr_q;
    mem_we     = 1'b0;
    mem_waddr  = ptr_q;
    mem_wdata  = tcw_pkg::make_cell(tcw_pkg::BLANK_CODE, tcw_pkg::RESET_COLOR);
    mem_raddr  = ptr_q;
    pop_o      = 1'b0;
    load       = 1'b0;
    newline    = 1'b0;
    res_entry  = '0;
    res_scr    = 1'b0;

    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (ptr_q == LastAddr) begin
          ptr_d   = '0;
          state_d = tcw_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      tcw_pkg::ST_IDLE: begin
        mv_pend_d = 1'b0;
        if (!q_empty_i && out_free) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            tcw_pkg::OP_READ: begin
              mem_raddr = addr_i;
              state_d   = tcw_pkg::ST_READ;
            end
            tcw_pkg::OP_READ_NONE: begin
              load = 1'b1;
            end
            tcw_pkg::OP_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr_q;
              mem_wdata = tcw_pkg::make_cell(cmd_i.char_code, text_color_i);
              if (col_inc == ColsCnt) begin
                newline = 1'b1;
              end else begin
                cur_col_d  = col_inc[ColW-1:0];
                cur_addr_d = cur_addr_q + AddrW'(1);
                load       = 1'b1;
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              newline = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
          if (newline) begin
            cur_col_d = '0;
            if (cur_row_q == LastRow) begin
              cur_addr_d = row_base_q;
              ptr_d      = ColsAddr;
              state_d    = tcw_pkg::ST_SCROLL;
            end else begin
              cur_row_d  = cur_row_q + RowW'(1);
              row_base_d = row_base_q + ColsAddr;
              cur_addr_d = row_base_q + ColsAddr;
              load       = 1'b1;
            end
          end
        end
      end
      tcw_pkg::ST_READ: begin
        load      = 1'b1;
        res_entry = rd_data_q;
        state_d   = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SCROLL: begin
        mem_raddr = ptr_q;
        mv_addr_d = ptr_q - ColsAddr;
        mv_pend_d = 1'b1;
        if (mv_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = mv_addr_q;
          mem_wdata = rd_data_q;
        end
        if (ptr_q == LastAddr) begin
          state_d = tcw_pkg::ST_DRAIN;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      tcw_pkg::ST_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = mv_addr_q;
        mem_wdata = rd_data_q;
        ptr_d     = BotBase;
        state_d   = tcw_pkg::ST_BLANK;
      end
      tcw_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::make_cell(tcw_pkg::BLANK_CODE, text_color_i);
        if (ptr_q == LastAddr) begin
          load    = 1'b1;
          res_scr = 1'b1;
          state_d = tcw_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  assign row_ext = RowExtW'(cur_row_d);
  assign col_ext = ColExtW'(cur_col_d);

  always_comb begin
    out_valid_d = out_valid_q;
    out_entry_d = out_entry_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_scr_d   = out_scr_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_entry_d = res_entry;
      out_row_d   = row_ext[tcw_pkg::RowFieldW-1:0];
      out_col_d   = col_ext[tcw_pkg::ColFieldW-1:0];
      out_scr_d   = res_scr;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign clearing_o       = state_q == tcw_pkg::ST_CLEAR;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cell_entry = out_entry_q;
  assign rsp_o.cursor_row = out_row_q;
  assign rsp_o.cursor_col = out_col_q;
  assign rsp_o.scrolled   = out_scr_q;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for text_console_writer: drives put and read requests, checks
// every response against an in-bench model of the screen store and cursor.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if and the text_console_writer RTL.
module testbench;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int STUCK_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 95;
  localparam int MAX_REPORTS = 60;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic [tcw_pkg::CharW-1:0]     char_code;
    logic [tcw_pkg::RowFieldW-1:0] cell_row;
    logic [tcw_pkg::ColFieldW-1:0] cell_col;
  } console_req_t;

  typedef struct packed {
    logic [tcw_pkg::CellW-1:0]     cell_entry;
    logic [tcw_pkg::RowFieldW-1:0] cursor_row;
    logic [tcw_pkg::ColFieldW-1:0] cursor_col;
    logic                          scrolled;
  } console_rsp_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  tcw_req_if req_bus();
  tcw_rsp_if rsp_bus();

  text_console_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Screen model and cursor.
  logic [tcw_pkg::CellW-1:0] screen_model [ROWS*COLS];
  int                        cursor_row_model;
  int                        cursor_col_model;
  logic [tcw_pkg::CharW-1:0] text_color_model;

  console_req_t req_backlog [$];
  console_rsp_t awaited_replies [$];
  console_req_t req_on_bus;
  bit           req_taken;
  int           reqs_queued, reqs_taken;
  int           put_count, read_count, scroll_count, color_count;
  int           error_count;
  int           burst_left, gap_left;
  int           stall_left, stall_style;
  logic [7:0]   stall_pattern;
  int           stuck_cycles;

  function automatic bit line_feed();
    cursor_col_model = 0;
    cursor_row_model++;
    if (cursor_row_model >= ROWS) begin
      for (int i = 0; i < (ROWS-1)*COLS; i++) screen_model[i] = screen_model[i+COLS];
      for (int i = 0; i < COLS; i++)
        screen_model[(ROWS-1)*COLS+i] = {text_color_model, tcw_pkg::BLANK_CODE};
      cursor_row_model = ROWS - 1;
      scroll_count++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_rsp_t apply_console_req(console_req_t rq);
    console_rsp_t rs;
    rs = '0;
    if (rq.req_type == REQ_READ) begin
      if (rq.cell_row < ROWS && rq.cell_col < COLS)
        rs.cell_entry = screen_model[int'(rq.cell_row)*COLS + int'(rq.cell_col)];
    end else if (rq.char_code == tcw_pkg::NEWLINE_CODE) begin
      rs.scrolled = line_feed();
    end else begin
      screen_model[cursor_row_model*COLS + cursor_col_model] = {text_color_model, rq.char_code};
      cursor_col_model++;
      if (cursor_col_model >= COLS) rs.scrolled = line_feed();
    end
    rs.cursor_row = cursor_row_model[tcw_pkg::RowFieldW-1:0];
    rs.cursor_col = cursor_col_model[tcw_pkg::ColFieldW-1:0];
    return rs;
  endfunction

  // Prediction on request beats, checking on response beats.
  always @(posedge clk_i) begin
    console_rsp_t want;
    if (rst_ni) begin
      if (cfg_we_i) text_color_model = cfg_wdata_i;
      if (req_bus.valid && req_bus.ready) begin
        awaited_replies.push_back(apply_console_req(req_on_bus));
        req_taken = 1'b1;
        reqs_taken++;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (awaited_replies.size() == 0) begin
          error_count++;
          $display("%0t: response beat with none expected, entry %h row %0d col %0d scrolled %b",
                   $time, rsp_bus.cell_entry, rsp_bus.cursor_row, rsp_bus.cursor_col,
                   rsp_bus.scrolled);
        end else begin
          want = awaited_replies.pop_front();
          if (rsp_bus.cell_entry !== want.cell_entry) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: cell_entry expected %h actual %h", $time, want.cell_entry,
                       rsp_bus.cell_entry);
          end
          if (rsp_bus.cursor_row !== want.cursor_row) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: cursor_row expected %0d actual %0d", $time, want.cursor_row,
                       rsp_bus.cursor_row);
          end
          if (rsp_bus.cursor_col !== want.cursor_col) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: cursor_col expected %0d actual %0d", $time, want.cursor_col,
                       rsp_bus.cursor_col);
          end
          if (rsp_bus.scrolled !== want.scrolled) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: scrolled expected %b actual %b", $time, want.scrolled,
                       rsp_bus.scrolled);
          end
        end
      end
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!req_bus.valid || req_taken)) begin
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (req_backlog.size() == 0) begin
        req_bus.valid <= 1'b0;
      end else begin
        req_on_bus = req_backlog.pop_front();
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= req_on_bus.req_type;
        req_bus.char_code <= req_on_bus.char_code;
        req_bus.cell_row  <= req_on_bus.cell_row;
        req_bus.cell_col  <= req_on_bus.cell_col;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Response stalls: always ready, coin flips, or a rotating pattern.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_left = $urandom_range(20, 200);
        stall_style = $urandom_range(0, 2);
        stall_pattern = 8'($urandom) | 8'h01;
      end
      stall_left--;
      case (stall_style)
        0: begin
          rsp_bus.ready <= 1'b1;
        end
        1: begin
          rsp_bus.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          rsp_bus.ready <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STUCK_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_req(logic kind, logic [7:0] ch, logic [4:0] row, logic [6:0] col);
    req_backlog.push_back('{req_type: kind, char_code: ch, cell_row: row, cell_col: col});
    reqs_queued++;
    if (kind == REQ_READ) read_count++;
    else put_count++;
  endtask

  task automatic queue_put(logic [7:0] ch);
    queue_req(REQ_PUT, ch, 5'($urandom), 7'($urandom));
  endtask

  task automatic queue_read(logic [4:0] row, logic [6:0] col);
    queue_req(REQ_READ, 8'($urandom), row, col);
  endtask

  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (reqs_taken != reqs_queued || awaited_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_text_color(logic [7:0] color);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= color;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    color_count++;
  endtask

  // Mostly runs of text and line feeds, with reads in and out of the screen.
  task automatic queue_random_phase(int n);
    int added;
    int pick;
    int run;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        run = $urandom_range(1, 20);
        repeat (run) queue_put(8'($urandom));
      end else if (pick == 4) begin
        run = $urandom_range(60, 85);
        repeat (run) queue_put(8'($urandom_range(0, 255)));
      end else if (pick <= 6) begin
        run = $urandom_range(1, 6);
        repeat (run) queue_put(tcw_pkg::NEWLINE_CODE);
      end else begin
        run = $urandom_range(1, 4);
        repeat (run) begin
          if ($urandom_range(0, 3) == 0)
            queue_read(5'($urandom), 7'($urandom));
          else if ($urandom_range(0, 2) == 0)
            queue_read(5'(ROWS - 1), 7'($urandom_range(0, COLS - 1)));
          else
            queue_read(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLS - 1)));
        end
      end
      added += run;
    end
  endtask

  initial begin
    logic [7:0] phase_colors [5];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_PUT;
    req_bus.char_code = '0;
    req_bus.cell_row = '0;
    req_bus.cell_col = '0;
    rsp_bus.ready = 1'b0;
    text_color_model = tcw_pkg::RESET_COLOR;
    cursor_row_model = 0;
    cursor_col_model = 0;
    for (int i = 0; i < ROWS*COLS; i++)
      screen_model[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CODE};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put(8'h41);
    queue_put(tcw_pkg::NEWLINE_CODE);
    queue_put(tcw_pkg::BLANK_CODE);
    queue_req(REQ_PUT, 8'h7E, 5'h1F, 7'h7F);
    queue_read(5'd0, 7'd0);
    queue_read(5'd0, 7'd1);
    queue_read(5'd0, 7'd2);
    queue_read(5'd1, 7'd0);
    queue_read(5'd1, 7'd1);
    queue_read(5'(ROWS - 1), 7'(COLS - 1));
    queue_read(5'd0, 7'(COLS - 1));
    queue_read(5'(ROWS), 7'd0);
    queue_read(5'd0, 7'(COLS));
    queue_req(REQ_READ, 8'hFF, 5'h1F, 7'h7F);
    queue_put(tcw_pkg::NEWLINE_CODE);
    wait_until_drained();

    phase_colors = '{8'h00, 8'hFF, 8'($urandom), 8'h1E, 8'($urandom_range(0, 255))};
    foreach (phase_colors[p]) begin
      write_text_color(phase_colors[p]);
      @(posedge clk_i);
      queue_read(5'd0, 7'd0);
      queue_read(5'd0, 7'd1);
      queue_random_phase(PHASE_ITEMS);
      wait_until_drained();
    end

    $display("Covered %0d puts and %0d reads over %0d text colors, with %0d screen scrolls.",
             put_count, read_count, color_count + 1, scroll_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
